### hdl/fud_pkg.sv
// Shared types, constants and helper functions for the file URI percent decoder.
`timescale 1ns / 1ps

package fud_pkg;

   localparam int CHAR_W      = 8;
   localparam int KIND_W      = 2;
   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int RES_CNT_W   = 2;

   localparam logic [2:0] PREFIX_LEN = 3'd7;

   localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_PERCENT = 8'h25;

   typedef struct packed {
      logic [CHAR_W-1:0] char_out;
      logic [KIND_W-1:0] kind;
      logic              end_of_uri;
   } result_type;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] value;
   } hex_type;

   // Expected scheme byte at each prefix position ("file://").
   function automatic logic [CHAR_W-1:0] prefix_char(input logic [2:0] pos);
      logic [CHAR_W-1:0] ch;
      case (pos)
         3'd0:    ch = 8'h66;
         3'd1:    ch = 8'h69;
         3'd2:    ch = 8'h6C;
         3'd3:    ch = 8'h65;
         3'd4:    ch = 8'h3A;
         3'd5:    ch = 8'h2F;
         3'd6:    ch = 8'h2F;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic hex_type hex_decode(input logic [CHAR_W-1:0] c);
      hex_type           h;
      logic [CHAR_W-1:0] diff;
      h    = '0;
      diff = '0;
      if (c inside {[8'h30:8'h39]}) begin
         diff = c - 8'h30;
         h.is_hex = 1'b1;
      end else if (c inside {[8'h61:8'h66]}) begin
         diff = c - 8'h57;
         h.is_hex = 1'b1;
      end else if (c inside {[8'h41:8'h46]}) begin
         diff = c - 8'h37;
         h.is_hex = 1'b1;
      end
      h.value = diff[3:0];
      return h;
   endfunction

   function automatic result_type make_result(input logic [CHAR_W-1:0] ch,
                                              input logic [KIND_W-1:0] kind,
                                              input logic              last);
      result_type r;
      r.char_out   = ch;
      r.kind       = kind;
      r.end_of_uri = last;
      return r;
   endfunction

endpackage

### hdl/fud_decode.sv
// Prefix check and percent decode of one word, with the per-URI decode state.
`timescale 1ns / 1ps

module fud_decode (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        take,
   input  logic [fud_pkg::CHAR_W-1:0]  char_in,
   input  logic                        final_char,
   output logic [fud_pkg::RES_CNT_W-1:0] res_count,
   output fud_pkg::result_type         res [fud_pkg::MAX_RESULTS]
);

   localparam logic [1:0] PH_PLAIN   = 2'd0;
   localparam logic [1:0] PH_PERCENT = 2'd1;
   localparam logic [1:0] PH_DIGIT   = 2'd2;
   localparam logic [1:0] PH_SWALLOW = 2'd3;

   logic [2:0]                  pos_ff, pos_in;
   logic [1:0]                  phase_ff, phase_in;
   logic [fud_pkg::CHAR_W-1:0]  held_ff, held_in;

   always_comb begin
      logic [fud_pkg::RES_CNT_W-1:0] n;
      logic                          do_plain;
      fud_pkg::hex_type              hex_c;
      fud_pkg::hex_type              hex_h;

      n        = '0;
      do_plain = 1'b0;
      hex_c    = fud_pkg::hex_decode(char_in);
      hex_h    = fud_pkg::hex_decode(held_ff);
      pos_in   = pos_ff;
      phase_in = phase_ff;
      held_in  = held_ff;
      for (int i = 0; i < fud_pkg::MAX_RESULTS; i++) begin
         res[i] = '0;
      end

      if (phase_ff == PH_SWALLOW) begin
         // drop the rest of a rejected URI
      end else if (pos_ff != fud_pkg::PREFIX_LEN) begin
         if (char_in != fud_pkg::prefix_char(pos_ff)) begin
            res[n]   = fud_pkg::make_result('0, fud_pkg::KIND_REJECT, 1'b1);
            n        = n + 2'd1;
            phase_in = PH_SWALLOW;
         end else begin
            pos_in = pos_ff + 3'd1;
            if (final_char) begin
               res[n] = fud_pkg::make_result('0,
                  (pos_in == fud_pkg::PREFIX_LEN) ? fud_pkg::KIND_EMPTY
                                                  : fud_pkg::KIND_REJECT, 1'b1);
               n = n + 2'd1;
            end
         end
      end else begin
         case (phase_ff)
            PH_PLAIN: begin
               do_plain = 1'b1;
            end
            PH_PERCENT: begin
               if (hex_c.is_hex) begin
                  if (final_char) begin
                     res[n] = fud_pkg::make_result(fud_pkg::CHAR_PERCENT,
                                                   fud_pkg::KIND_DATA, 1'b0);
                     n = n + 2'd1;
                     res[n] = fud_pkg::make_result(char_in, fud_pkg::KIND_DATA, 1'b1);
                     n = n + 2'd1;
                  end else begin
                     held_in  = char_in;
                     phase_in = PH_DIGIT;
                  end
               end else begin
                  res[n] = fud_pkg::make_result(fud_pkg::CHAR_PERCENT,
                                                fud_pkg::KIND_DATA, 1'b0);
                  n = n + 2'd1;
                  do_plain = 1'b1;
               end
            end
            default: begin
               if (hex_c.is_hex && hex_h.is_hex) begin
                  res[n] = fud_pkg::make_result({hex_h.value, hex_c.value},
                                                fud_pkg::KIND_DATA, final_char);
                  n = n + 2'd1;
                  phase_in = PH_PLAIN;
                  held_in  = '0;
               end else begin
                  // broken pair: flush percent and held digit, then treat byte as plain
                  res[n] = fud_pkg::make_result(fud_pkg::CHAR_PERCENT,
                                                fud_pkg::KIND_DATA, 1'b0);
                  n = n + 2'd1;
                  res[n] = fud_pkg::make_result(held_ff, fud_pkg::KIND_DATA, 1'b0);
                  n = n + 2'd1;
                  held_in  = '0;
                  do_plain = 1'b1;
               end
            end
         endcase
      end

      if (do_plain) begin
         if (char_in == fud_pkg::CHAR_PERCENT) begin
            if (final_char) begin
               res[n] = fud_pkg::make_result(fud_pkg::CHAR_PERCENT,
                                             fud_pkg::KIND_DATA, 1'b1);
               n = n + 2'd1;
            end else begin
               phase_in = PH_PERCENT;
            end
         end else begin
            res[n] = fud_pkg::make_result(char_in, fud_pkg::KIND_DATA, final_char);
            n = n + 2'd1;
            phase_in = PH_PLAIN;
         end
      end

      if (final_char) begin
         pos_in   = '0;
         phase_in = PH_PLAIN;
         held_in  = '0;
      end

      res_count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         phase_ff <= PH_PLAIN;
         held_ff  <= '0;
      end else if (take) begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

endmodule

### hdl/fud_queue.sv
// Result queue: takes up to three results a cycle, hands out one word a cycle while rsp_ready is high.
`timescale 1ns / 1ps

module fud_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [fud_pkg::RES_CNT_W-1:0] push_count,
   input  fud_pkg::result_type           push_res [fud_pkg::MAX_RESULTS],
   output logic                          room,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output fud_pkg::result_type           head
);

   localparam int PTR_W = $clog2(fud_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(fud_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] ROOM_LIMIT =
      CNT_W'(fud_pkg::QUEUE_DEPTH - fud_pkg::MAX_RESULTS);

   fud_pkg::result_type mem_ff [fud_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                pop;

   assign rsp_valid = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   // Leave space for a full burst of results after this cycle's pop.
   assign room      = (count_ff - CNT_W'(pop)) <= ROOM_LIMIT;

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(push_count) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < fud_pkg::MAX_RESULTS; i++) begin
         if (fud_pkg::RES_CNT_W'(i) < push_count) begin
            mem_ff[wr_ptr_ff + PTR_W'(i)] <= push_res[i];
         end
      end
   end

endmodule

### hdl/file_uri_percent_decoder.sv
// A word accepted into the input register is decoded from it combinationally, and its
// results are written into the result queue when there is room, then shown on rsp_*.
// Throughput: one input word per cycle while the result queue has room; results leave the
// queue one per cycle while rsp_ready is high; a word with three results can stall input.
// Reset (synchronous, active high) empties the input register and result queue and
// clears prefix count, decode phase and held digit.
`timescale 1ns / 1ps

module file_uri_percent_decoder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [fud_pkg::CHAR_W-1:0] req_char_in,
   input  logic                       req_final_char,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [fud_pkg::CHAR_W-1:0] rsp_char_out,
   output logic [fud_pkg::KIND_W-1:0] rsp_kind,
   output logic                       rsp_end_of_uri
);

   logic                          in_valid_ff;
   logic [fud_pkg::CHAR_W-1:0]    in_char_ff;
   logic                          in_final_ff;
   logic                          take;
   logic                          room;
   logic [fud_pkg::RES_CNT_W-1:0] res_count;
   logic [fud_pkg::RES_CNT_W-1:0] push_count;
   fud_pkg::result_type           res [fud_pkg::MAX_RESULTS];
   fud_pkg::result_type           head;

   assign take       = in_valid_ff && room;
   assign req_ready  = !in_valid_ff || take;
   assign push_count = take ? res_count : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff  <= req_char_in;
         in_final_ff <= req_final_char;
      end
   end

   fud_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .char_in    (in_char_ff),
      .final_char (in_final_ff),
      .res_count  (res_count),
      .res        (res)
   );

   fud_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_res   (res),
      .room       (room),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .head       (head)
   );

   assign rsp_char_out   = head.char_out;
   assign rsp_kind       = head.kind;
   assign rsp_end_of_uri = head.end_of_uri;

endmodule

### test/file_uri_percent_decoder_test.sv
`timescale 1ns / 1ps
// Testbench for the file URI percent decoder: directed and random URIs, behavioral check.

module file_uri_percent_decoder_test;

   localparam int          WORD_TARGET = 410;
   localparam int          CYCLE_LIMIT = 200000;
   localparam int          TAIL_CYCLES = 20;
   localparam logic [55:0] SCHEME      = "file://";

   localparam logic [1:0] DEC_PLAIN   = 2'd0;
   localparam logic [1:0] DEC_PERCENT = 2'd1;
   localparam logic [1:0] DEC_DIGIT   = 2'd2;
   localparam logic [1:0] DEC_SWALLOW = 2'd3;

   typedef struct packed {
      logic [fud_pkg::CHAR_W-1:0] ch;
      logic                       fin;
   } uri_word_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [fud_pkg::CHAR_W-1:0] req_char_in = '0;
   logic                       req_final_char = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [fud_pkg::CHAR_W-1:0] rsp_char_out;
   logic [fud_pkg::KIND_W-1:0] rsp_kind;
   logic                       rsp_end_of_uri;

   uri_word_type        uri_words[$];
   fud_pkg::result_type decoded_results[$];

   int words_total = 0;
   int words_in    = 0;
   int uris_in     = 0;
   int bytes_out   = 0;
   int empties_out = 0;
   int rejects_out = 0;
   int mismatches  = 0;
   int cycle_cnt   = 0;
   int idle_mode   = 0;
   logic in_taken  = 1'b0;

   // decoder state
   logic [2:0]                 scheme_pos = '0;
   logic [1:0]                 dec_state  = DEC_PLAIN;
   logic [fud_pkg::CHAR_W-1:0] held_char  = '0;

   file_uri_percent_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_char_in    (req_char_in),
      .req_final_char (req_final_char),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_char_out   (rsp_char_out),
      .rsp_kind       (rsp_kind),
      .rsp_end_of_uri (rsp_end_of_uri)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic is_hex(input logic [fud_pkg::CHAR_W-1:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   // letters carry their value minus nine in the low nibble
   function automatic logic [3:0] hex_nibble(input logic [fud_pkg::CHAR_W-1:0] c);
      return (c <= "9") ? c[3:0] : c[3:0] + 4'd9;
   endfunction

   task automatic queue_result(input logic [fud_pkg::CHAR_W-1:0] ch,
                               input logic [fud_pkg::KIND_W-1:0] kind,
                               input logic last);
      fud_pkg::result_type r;
      r.char_out   = ch;
      r.kind       = kind;
      r.end_of_uri = last;
      decoded_results = {decoded_results, r};
   endtask

   task automatic plain_char(input logic [fud_pkg::CHAR_W-1:0] c, input logic fin);
      if (c == fud_pkg::CHAR_PERCENT) begin
         if (fin)
            queue_result(fud_pkg::CHAR_PERCENT, fud_pkg::KIND_DATA, 1'b1);
         else
            dec_state = DEC_PERCENT;
      end else begin
         queue_result(c, fud_pkg::KIND_DATA, fin);
         dec_state = DEC_PLAIN;
      end
   endtask

   task automatic decode_word(input logic [fud_pkg::CHAR_W-1:0] c, input logic fin);
      if (dec_state == DEC_SWALLOW) begin
         // rest of a rejected URI gives nothing
      end else if (scheme_pos < fud_pkg::PREFIX_LEN) begin
         if (c != SCHEME[55 - 8*scheme_pos -: 8]) begin
            queue_result('0, fud_pkg::KIND_REJECT, 1'b1);
            dec_state = DEC_SWALLOW;
         end else begin
            scheme_pos = scheme_pos + 3'd1;
            if (fin)
               queue_result('0, (scheme_pos == fud_pkg::PREFIX_LEN) ? fud_pkg::KIND_EMPTY
                                                                    : fud_pkg::KIND_REJECT,
                            1'b1);
         end
      end else begin
         case (dec_state)
            DEC_PLAIN: begin
               plain_char(c, fin);
            end
            DEC_PERCENT: begin
               if (is_hex(c)) begin
                  if (fin) begin
                     queue_result(fud_pkg::CHAR_PERCENT, fud_pkg::KIND_DATA, 1'b0);
                     queue_result(c, fud_pkg::KIND_DATA, 1'b1);
                  end else begin
                     held_char = c;
                     dec_state = DEC_DIGIT;
                  end
               end else begin
                  queue_result(fud_pkg::CHAR_PERCENT, fud_pkg::KIND_DATA, 1'b0);
                  plain_char(c, fin);
               end
            end
            default: begin
               if (is_hex(c)) begin
                  queue_result({hex_nibble(held_char), hex_nibble(c)}, fud_pkg::KIND_DATA,
                               fin);
                  dec_state = DEC_PLAIN;
               end else begin
                  // broken pair: flush '%' and the held digit, then treat c as plain
                  queue_result(fud_pkg::CHAR_PERCENT, fud_pkg::KIND_DATA, 1'b0);
                  queue_result(held_char, fud_pkg::KIND_DATA, 1'b0);
                  plain_char(c, fin);
               end
               held_char = '0;
            end
         endcase
      end
      if (fin) begin
         scheme_pos = '0;
         dec_state  = DEC_PLAIN;
         held_char  = '0;
      end
   endtask

   task automatic add_word(input logic [fud_pkg::CHAR_W-1:0] ch, input logic fin);
      uri_word_type w;
      w.ch  = ch;
      w.fin = fin;
      uri_words = {uri_words, w};
   endtask

   task automatic add_text(input string s, input logic fin_last);
      for (int i = 0; i < s.len(); i++)
         add_word(s[i], fin_last && (i == s.len() - 1));
   endtask

   // sender: advance to the next word once the current one is taken
   always @(negedge clock) begin
      int           send_idle;
      uri_word_type w;
      send_idle = (idle_mode == 1) ? 68 : (idle_mode == 3) ? 20 : 0;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || in_taken) begin
         if (uri_words.size() != 0 && $urandom_range(99) >= send_idle) begin
            w = uri_words.pop_front();
            req_char_in    <= w.ch;
            req_final_char <= w.fin;
            req_valid      <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      int stall;
      stall = (idle_mode == 2) ? 68 : (idle_mode == 3) ? 20 : 0;
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= stall);
   end

   always @(posedge clock) begin
      fud_pkg::result_type got;
      fud_pkg::result_type want;
      in_taken = 1'b0;
      if (!reset) begin
         // predict first so a word's results are queued before they can show up
         if (req_valid && req_ready) begin
            decode_word(req_char_in, req_final_char);
            in_taken = 1'b1;
            words_in++;
            if (req_final_char)
               uris_in++;
            idle_mode = (words_in * 4) / words_total;
            if (idle_mode > 3)
               idle_mode = 3;
         end
         if (rsp_valid && rsp_ready) begin
            got.char_out   = rsp_char_out;
            got.kind       = rsp_kind;
            got.end_of_uri = rsp_end_of_uri;
            case (got.kind)
               fud_pkg::KIND_DATA:  bytes_out++;
               fud_pkg::KIND_EMPTY: empties_out++;
               default:             rejects_out++;
            endcase
            if (decoded_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result char %h kind %0d end %b", $realtime,
                           got.char_out, got.kind, got.end_of_uri);
            end else begin
               want = decoded_results.pop_front();
               if (got.char_out !== want.char_out || got.kind !== want.kind ||
                   got.end_of_uri !== want.end_of_uri) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch char %h/%h kind %0d/%0d end %b/%b (exp/got)",
                              $realtime, want.char_out, got.char_out, want.kind, got.kind,
                              want.end_of_uri, got.end_of_uri);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d of %0d words in, %0d results pending",
                  cycle_cnt, words_in, words_total, decoded_results.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int          roll;
      int          plen;
      int          cut;
      int          tail;
      int          pick;
      logic [7:0]  b;
      string       hex_chars;
      hex_chars = "0123456789abcdefABCDEF";

      add_text("file://", 1'b1);           // bare prefix
      add_text("fi", 1'b1);                // short prefix
      add_word(8'hFF, 1'b0);               // bad first byte, rest swallowed
      add_word(8'h00, 1'b1);
      add_text("file://%4f%G", 1'b0);      // decoded pair, then a percent with no hex digit
      add_word(8'hFF, 1'b0);
      add_text("%7%", 1'b1);               // held digit flushed, trailing percent

      while (uri_words.size() < WORD_TARGET) begin
         roll = $urandom_range(99);
         if (roll < 75) begin
            plen = ($urandom_range(3) == 0) ? $urandom_range(1) : $urandom_range(2, 10);
            add_text("file://", plen == 0);
            for (int i = 0; i < plen; i++) begin
               pick = $urandom_range(99);
               if (pick < 30)
                  b = fud_pkg::CHAR_PERCENT;
               else if (pick < 60)
                  b = hex_chars[$urandom_range(21)];
               else if (pick < 75)
                  b = 8'($urandom_range(255));
               else
                  b = 8'($urandom_range(8'h20, 8'h7E));
               add_word(b, i == plen - 1);
            end
         end else if (roll < 88) begin
            cut = $urandom_range(6);
            for (int i = 0; i < cut; i++)
               add_word(SCHEME[55 - 8*i -: 8], 1'b0);
            if ($urandom_range(1)) begin
               add_word(SCHEME[55 - 8*cut -: 8], 1'b1);
            end else begin
               tail = $urandom_range(4);
               add_word(8'($urandom_range(255)), tail == 0);
               for (int i = 0; i < tail; i++)
                  add_word(8'($urandom_range(255)), i == tail - 1);
            end
         end else begin
            tail = $urandom_range(1, 6);
            for (int i = 0; i < tail; i++)
               add_word(8'($urandom_range(255)), i == tail - 1);
         end
      end
      words_total = uri_words.size();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (words_in < words_total)
         @(posedge clock);
      while (decoded_results.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d URIs in %0d words, %0d results (%0d bytes, %0d empty paths, %0d rejects)",
               uris_in, words_in, bytes_out + empties_out + rejects_out, bytes_out,
               empties_out, rejects_out);
      $display("ran free, with input gaps, output stalls and both; %0d mismatches", mismatches);
      if (mismatches == 0 && decoded_results.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
